### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### rtl/asst_pkg.sv
// ---------------------------------------------------------------------------
// asst_pkg
// Types and constants shared by the shot split timer and its checker.
// ---------------------------------------------------------------------------
package asst_pkg;

  localparam int unsigned MaxShotsDefault = 64;

  localparam int unsigned MsPerSecond = 1000;
  localparam int unsigned MsPerTick   = 10;

  // configuration register indexes
  localparam logic [1:0] CFG_START_DELAY   = 2'd0;
  localparam logic [1:0] CFG_MIC_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_MIN_SPLIT     = 2'd2;

  localparam logic [7:0] StartDelayReset   = 8'd3;
  localparam logic [9:0] MicThresholdReset = 10'd50;
  localparam logic [7:0] MinSplitReset     = 8'd10;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_ARMED   = 2'd1,
    MODE_GO      = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_POLL   = 2'd0,
    OP_ROLL   = 2'd1,
    OP_BUTTON = 2'd2
  } op_e;

  typedef enum logic {
    PH_IDLE   = 1'b0,
    PH_RESULT = 1'b1
  } phase_e;

endpackage

### rtl/asst_ram.sv
// ---------------------------------------------------------------------------
// asst_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low; read during write to the
// same address returns the old contents.
// ---------------------------------------------------------------------------
module asst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/acoustic_shot_split_timer_top.sv
// ---------------------------------------------------------------------------
// acoustic_shot_split_timer_top
// Shot timer with ready/set/go modes, a shot log in RAM and split readout.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): one beat per event, a poll with a
// time stamp and mic sample, a roll step, or the start/stop button.
// Output channel (out_valid_o / out_stall_i): exactly one result beat per
// input beat, in order, with mode, redraw and beep flags, the shown and last
// shot indexes, first-shot time, shown-shot split and total, and peak sample.
// Config port: cfg_we_i writes cfg_data_i to register cfg_index_i; write
// only while no event is in flight.
// At the accept edge the state registers update, the log is written and the
// log RAM read is registered; the result phase then loads the output register.
// The input stalls in the result phase, so a new event waits for that load.
// A stalled output holds the block in its result phase, with in_stall_o high,
// until the pending beat is taken.
// Reset clears mode, indexes, the start time stamp, peak and config registers
// to their defaults; the log RAM is not cleared and needs no clearing pass,
// entries are only used once written.
// ---------------------------------------------------------------------------
module acoustic_shot_split_timer_top #(
  parameter int unsigned MaxShots = asst_pkg::MaxShotsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [9:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [31:0]       now_ms_i,
  input  logic [9:0]        sample_i,
  input  logic signed [1:0] roll_dir_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        mode_o,
  output logic              refresh_o,
  output logic              beep_o,
  output logic signed [6:0] shown_index_o,
  output logic signed [6:0] shot_count_index_o,
  output logic [31:0]       first_ms_o,
  output logic [31:0]       split_ms_o,
  output logic [31:0]       total_ms_o,
  output logic [9:0]        peak_sample_o
);
  import asst_pkg::*;

  localparam int AddrW = (MaxShots > 1) ? $clog2(MaxShots) : 1;
  localparam int IdxW  = AddrW + 1;
  localparam logic signed [IdxW-1:0] IdxNone = '1;
  localparam logic signed [IdxW-1:0] IdxTop  = IdxW'(MaxShots - 1);

  // config
  logic [7:0] start_delay_q;
  logic [9:0] mic_threshold_q;
  logic [7:0] min_split_q;

  // block state
  mode_e                  mode_q, mode_d;
  logic [31:0]            start_stamp_q, start_stamp_d;
  logic signed [IdxW-1:0] last_idx_q, last_idx_d;
  logic signed [IdxW-1:0] browse_idx_q, browse_idx_d;
  logic [9:0]             prev_sample_q, prev_sample_d;
  logic [9:0]             peak_q, peak_d;
  logic [31:0]            first_stamp_q;  // copy of log entry 0
  logic [31:0]            last_stamp_q;   // copy of newest log entry

  // handshake / result phase
  phase_e                 phase_q, phase_d;
  logic                   in_acc, res_load;
  logic signed [IdxW-1:0] shown_q, shown_d;
  logic                   refresh_q, refresh_d;
  logic                   beep_q, beep_d;
  logic                   fwd_q;
  logic                   log_we;
  logic                   show_last;

  // output register
  logic                   out_valid_q;
  logic [1:0]             mode_out_q;
  logic                   refresh_out_q, beep_out_q;
  logic signed [6:0]      shown_out_q, count_out_q;
  logic [31:0]            first_out_q, split_out_q, total_out_q;
  logic [9:0]             peak_out_q;

  // accept-cycle arithmetic
  logic [17:0]            delay_ms;
  logic [11:0]            min_split_ms;
  logic                   delay_done;
  logic [10:0]            shot_level;
  logic                   shot_hit;
  logic [31:0]            fire_base;
  logic                   split_ok;
  logic signed [IdxW-1:0] next_idx;
  logic                   dir_fwd, dir_back;

  // result-cycle datapath
  logic [31:0]            rd_cur, rd_prev;
  logic [31:0]            cur_stamp, before_stamp;
  logic                   has_shot;
  logic signed [31:0]     shown_ext, last_ext;
  logic [AddrW-1:0]       raddr_cur, raddr_prev;

  assign delay_ms     = 18'(start_delay_q) * 18'(MsPerSecond);
  assign min_split_ms = 12'(min_split_q) * 12'(MsPerTick);
  assign delay_done   = (now_ms_i - start_stamp_q) >= 32'(delay_ms);
  assign shot_level   = {1'b0, prev_sample_q} + {1'b0, mic_threshold_q};
  assign shot_hit     = {1'b0, sample_i} > shot_level;
  assign fire_base    = last_idx_q[IdxW-1] ? start_stamp_q : last_stamp_q;
  assign split_ok     = (now_ms_i - fire_base) >= 32'(min_split_ms);
  assign next_idx     = (last_idx_q == IdxTop) ? '0 : last_idx_q + IdxW'(1);
  assign dir_fwd      = (roll_dir_i == 2'sb01);
  assign dir_back     = roll_dir_i[1];

  // event decode
  always_comb begin
    mode_d        = mode_q;
    start_stamp_d = start_stamp_q;
    last_idx_d    = last_idx_q;
    browse_idx_d  = browse_idx_q;
    prev_sample_d = prev_sample_q;
    peak_d        = peak_q;
    refresh_d     = 1'b0;
    beep_d        = 1'b0;
    log_we        = 1'b0;
    show_last     = 1'b0;
    case (op_e'(operation_i))
      OP_POLL: begin
        case (mode_q)
          MODE_ARMED: begin
            if (delay_done) begin
              start_stamp_d = now_ms_i;
              mode_d        = MODE_GO;
              last_idx_d    = IdxNone;
              beep_d        = 1'b1;
              refresh_d     = 1'b1;
              show_last     = 1'b1;
            end
          end
          MODE_GO: begin
            if (shot_hit) begin
              refresh_d = 1'b1;
              show_last = 1'b1;
              // too short a split is dropped but still redraws
              if (split_ok) begin
                last_idx_d   = next_idx;
                browse_idx_d = next_idx;
                log_we       = 1'b1;
              end
            end
            prev_sample_d = sample_i;
            if (sample_i > peak_q) begin
              peak_d = sample_i;
            end
          end
          default: ;
        endcase
      end
      OP_ROLL: begin
        if (last_idx_q != IdxNone) begin
          if (dir_fwd) begin
            browse_idx_d = (browse_idx_q >= last_idx_q) ? '0 : browse_idx_q + IdxW'(1);
          end else if (dir_back) begin
            browse_idx_d = (browse_idx_q[IdxW-1] || browse_idx_q == '0) ?
                           last_idx_q : browse_idx_q - IdxW'(1);
          end
        end
        refresh_d = 1'b1;
      end
      OP_BUTTON: begin
        if (mode_q == MODE_STANDBY) begin
          start_stamp_d = now_ms_i;
          mode_d        = MODE_ARMED;
          browse_idx_d  = IdxNone;
          peak_d        = '0;
        end else begin
          mode_d = MODE_STANDBY;
        end
        refresh_d = 1'b1;
      end
      default: ;
    endcase
    shown_d = show_last ? last_idx_d : browse_idx_d;
  end

  // phase control
  always_comb begin
    phase_d    = phase_q;
    in_stall_o = 1'b1;
    in_acc     = 1'b0;
    res_load   = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        in_stall_o = 1'b0;
        in_acc     = in_valid_i;
        if (in_valid_i) begin
          phase_d = PH_RESULT;
        end
      end
      PH_RESULT: begin
        res_load = !out_valid_q || !out_stall_i;
        if (res_load) begin
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q   <= StartDelayReset;
      mic_threshold_q <= MicThresholdReset;
      min_split_q     <= MinSplitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_DELAY:   start_delay_q   <= cfg_data_i[7:0];
        CFG_MIC_THRESHOLD: mic_threshold_q <= cfg_data_i;
        CFG_MIN_SPLIT:     min_split_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_STANDBY;
      start_stamp_q <= '0;
      last_idx_q    <= IdxNone;
      browse_idx_q  <= IdxNone;
      prev_sample_q <= '0;
      peak_q        <= '0;
    end else if (in_acc) begin
      mode_q        <= mode_d;
      start_stamp_q <= start_stamp_d;
      last_idx_q    <= last_idx_d;
      browse_idx_q  <= browse_idx_d;
      prev_sample_q <= prev_sample_d;
      peak_q        <= peak_d;
    end
  end

  // per-beat context for the result cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      shown_q   <= shown_d;
      refresh_q <= refresh_d;
      beep_q    <= beep_d;
      fwd_q     <= log_we;
      if (log_we) begin
        last_stamp_q <= now_ms_i;
        if (next_idx == '0) begin
          first_stamp_q <= now_ms_i;
        end
      end
    end
  end

  // Two copies of the log so the shown shot and its predecessor read together.
  assign raddr_cur  = shown_d[AddrW-1:0];
  assign raddr_prev = shown_d[AddrW-1:0] - AddrW'(1);

  asst_ram #(
    .Width (32),
    .Depth (MaxShots)
  ) u_log_cur (
    .clk_i   (clk_i),
    .we_i    (in_acc && log_we),
    .waddr_i (next_idx[AddrW-1:0]),
    .wdata_i (now_ms_i),
    .re_i    (in_acc),
    .raddr_i (raddr_cur),
    .rdata_o (rd_cur)
  );

  asst_ram #(
    .Width (32),
    .Depth (MaxShots)
  ) u_log_prev (
    .clk_i   (clk_i),
    .we_i    (in_acc && log_we),
    .waddr_i (next_idx[AddrW-1:0]),
    .wdata_i (now_ms_i),
    .re_i    (in_acc),
    .raddr_i (raddr_prev),
    .rdata_o (rd_prev)
  );

  // a shot logged this beat is always the one shown; RAM read was read-first
  assign cur_stamp    = fwd_q ? last_stamp_q : rd_cur;
  assign before_stamp = (shown_q == '0) ? start_stamp_q : rd_prev;
  assign has_shot     = !shown_q[IdxW-1];
  assign shown_ext    = 32'(shown_q);
  assign last_ext     = 32'(last_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      mode_out_q    <= mode_q;
      refresh_out_q <= refresh_q;
      beep_out_q    <= beep_q;
      shown_out_q   <= shown_ext[6:0];
      count_out_q   <= last_ext[6:0];
      first_out_q   <= has_shot ? first_stamp_q - start_stamp_q : '0;
      split_out_q   <= has_shot ? cur_stamp - before_stamp : '0;
      total_out_q   <= has_shot ? cur_stamp - start_stamp_q : '0;
      peak_out_q    <= peak_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign mode_o             = mode_out_q;
  assign refresh_o          = refresh_out_q;
  assign beep_o             = beep_out_q;
  assign shown_index_o      = shown_out_q;
  assign shot_count_index_o = count_out_q;
  assign first_ms_o         = first_out_q;
  assign split_ms_o         = split_out_q;
  assign total_ms_o         = total_out_q;
  assign peak_sample_o      = peak_out_q;

endmodule

### rtl/asst_checker.sv
// ---------------------------------------------------------------------------
// asst_checker
// Port-level checks on the shot split timer, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module asst_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic [1:0]        cfg_index_i,
  input logic [9:0]        cfg_data_i,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [1:0]        operation_i,
  input logic [31:0]       now_ms_i,
  input logic [9:0]        sample_i,
  input logic signed [1:0] roll_dir_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        mode_o,
  input logic              refresh_o,
  input logic              beep_o,
  input logic signed [6:0] shown_index_o,
  input logic signed [6:0] shot_count_index_o,
  input logic [31:0]       first_ms_o,
  input logic [31:0]       split_ms_o,
  input logic [31:0]       total_ms_o,
  input logic [9:0]        peak_sample_o
);
  import asst_pkg::*;

  // one event in flight: the input closes for the result cycle
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a new result only comes out of the result cycle
  `ASSERT_IMPLY(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

  // start beep: run begins with an empty log and nothing shown
  `ASSERT_IMPLY(a_beep_clean_start, clk_i, rst_ni, out_valid_o && beep_o, mode_o == MODE_GO && refresh_o && shown_index_o == 7'h7f && shot_count_index_o == 7'h7f)

  // stalled beat holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(split_ms_o) && $stable(total_ms_o) && $stable(shown_index_o))

endmodule

bind acoustic_shot_split_timer_top asst_checker u_asst_checker (.*);
